>>> rtl/core/atrlp_pkg.sv
package atrlp_pkg;

	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_LINE    = 2'd1,
		KIND_PAYLOAD = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_OK    = 2'd1,
		CLS_ERROR = 2'd2
	} cls_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_ARM  = 1'b1
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} emit_state_t;

	// one result item; ok/err/prompt are the sticky flags after the step
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
		cls_t        cls;
		logic        ok;
		logic        err;
		logic        prompt;
	} res_t;

	localparam logic [7:0] CH_PROMPT = 8'h3E;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// response strings tracked character by character while a line is gathered
	localparam int STR_MAX = 9;
	localparam int NCAND   = 7;

	localparam int CAND_OK        = 0;
	localparam int CAND_SEND_OK   = 1;
	localparam int CAND_ERROR     = 2;
	localparam int CAND_FAIL      = 3;
	localparam int CAND_SEND_FAIL = 4;
	localparam int CAND_BUSY      = 5;
	localparam int CAND_IPD       = 6;

	localparam logic [8*STR_MAX-1:0] CAND_STR [NCAND] = '{
		"OK", "SEND OK", "ERROR", "FAIL", "SEND FAIL", "busy ", "+IPD,"
	};
	localparam int CAND_LEN [NCAND] = '{2, 7, 5, 4, 9, 5, 5};
	// candidates matched as a line prefix rather than the whole line
	localparam logic [NCAND-1:0] CAND_PREFIX = 7'b110_0000;

	localparam logic [5:0] IPD_MIN_LEN = 6'd6;

	function automatic logic cand_char_eq(int k, logic [5:0] idx, logic [7:0] c);
		logic eq;
		eq = 1'b0;
		for (int i = 0; i < STR_MAX; i++) begin
			if (i < CAND_LEN[k] && idx == 6'(i)) begin
				eq = (c == CAND_STR[k][(CAND_LEN[k] - 1 - i) * 8 +: 8]);
			end
		end
		return eq;
	endfunction

endpackage

>>> rtl/core/atrlp_ram.sv
module atrlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/atrlp_lex.sv
module atrlp_lex #(
	parameter int              LINE_BYTES  = 64,
	parameter int              CHUNK_BYTES = 64,
	parameter longint unsigned PAYLOAD_MAX = 65535
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          cmd,
	input  logic [7:0]                    rx_byte,
	output atrlp_pkg::res_t               res,
	output logic [$clog2(LINE_BYTES)-1:0] run_n,
	output logic                          wr_en,
	output logic [$clog2(LINE_BYTES)-1:0] wr_addr
);

	localparam int CNT_W = $clog2(LINE_BYTES);
	localparam int CH_W  = $clog2(CHUNK_BYTES + 1);
	localparam int PL_W  = $clog2(PAYLOAD_MAX + 1);
	localparam int ACC_W = $clog2(PAYLOAD_MAX + 2);
	localparam int PRD_W = ACC_W + 4;

	logic [CNT_W-1:0]            cnt_q, cnt_n;
	logic [PL_W-1:0]             pl_q, pl_n;
	logic [CH_W-1:0]             chunk_q, chunk_n, chunk_inc;
	logic                        ok_q, ok_n, err_q, err_n, prompt_q, prompt_n;
	logic [ACC_W-1:0]            acc_q, acc_n;
	logic                        donly_q, donly_n, dseen_q, dseen_n;
	logic [atrlp_pkg::NCAND-1:0] cand_q, cand_n;

	logic [5:0]       cnt6;
	logic             is_digit;
	logic [3:0]       digit;
	logic [PRD_W-1:0] prod;
	logic             hit_ok, hit_err, ipd_ok, pl_last;

	always_comb begin
		cnt6     = 6'(cnt_q);
		is_digit = rx_byte >= atrlp_pkg::CH_ZERO && rx_byte <= atrlp_pkg::CH_NINE;
		digit    = 4'(rx_byte - atrlp_pkg::CH_ZERO);
		prod     = (PRD_W'(acc_q) << 3) + (PRD_W'(acc_q) << 1) + PRD_W'(digit);

		hit_ok = (cand_q[atrlp_pkg::CAND_OK]
				&& cnt6 == 6'(atrlp_pkg::CAND_LEN[atrlp_pkg::CAND_OK]))
			|| (cand_q[atrlp_pkg::CAND_SEND_OK]
				&& cnt6 == 6'(atrlp_pkg::CAND_LEN[atrlp_pkg::CAND_SEND_OK]));
		hit_err = (cand_q[atrlp_pkg::CAND_ERROR]
				&& cnt6 == 6'(atrlp_pkg::CAND_LEN[atrlp_pkg::CAND_ERROR]))
			|| (cand_q[atrlp_pkg::CAND_FAIL]
				&& cnt6 == 6'(atrlp_pkg::CAND_LEN[atrlp_pkg::CAND_FAIL]))
			|| (cand_q[atrlp_pkg::CAND_SEND_FAIL]
				&& cnt6 == 6'(atrlp_pkg::CAND_LEN[atrlp_pkg::CAND_SEND_FAIL]))
			|| (cand_q[atrlp_pkg::CAND_BUSY]
				&& cnt6 >= 6'(atrlp_pkg::CAND_LEN[atrlp_pkg::CAND_BUSY]));
		ipd_ok = cand_q[atrlp_pkg::CAND_IPD] && cnt6 >= atrlp_pkg::IPD_MIN_LEN
			&& donly_q && dseen_q && acc_q <= ACC_W'(PAYLOAD_MAX);

		chunk_inc = chunk_q + 1'b1;
		pl_last   = (chunk_inc >= CH_W'(CHUNK_BYTES)) || (pl_q == PL_W'(1));

		cnt_n    = cnt_q;
		pl_n     = pl_q;
		chunk_n  = chunk_q;
		ok_n     = ok_q;
		err_n    = err_q;
		prompt_n = prompt_q;
		acc_n    = acc_q;
		donly_n  = donly_q;
		dseen_n  = dseen_q;
		cand_n   = cand_q;
		wr_en    = 1'b0;
		wr_addr  = cnt_q;
		run_n    = cnt_q;

		res.kind = atrlp_pkg::KIND_STATUS;
		res.data = 8'd0;
		res.last = 1'b0;
		res.cls  = atrlp_pkg::CLS_OTHER;

		if (cmd == atrlp_pkg::CMD_ARM) begin
			ok_n     = 1'b0;
			err_n    = 1'b0;
			prompt_n = 1'b0;
		end else if (pl_q != '0) begin
			pl_n     = pl_q - 1'b1;
			chunk_n  = pl_last ? '0 : chunk_inc;
			res.kind = atrlp_pkg::KIND_PAYLOAD;
			res.data = rx_byte;
			res.last = pl_last;
		end else begin
			priority if (rx_byte == atrlp_pkg::CH_PROMPT) begin
				prompt_n = 1'b1;
			end else if (rx_byte == atrlp_pkg::CH_CR) begin
				// drop
			end else if (rx_byte == atrlp_pkg::CH_LF) begin
				if (cnt_q != '0) begin
					res.kind = atrlp_pkg::KIND_LINE;
					if (hit_ok) begin
						ok_n    = 1'b1;
						res.cls = atrlp_pkg::CLS_OK;
					end else if (hit_err) begin
						err_n   = 1'b1;
						res.cls = atrlp_pkg::CLS_ERROR;
					end
					cnt_n   = '0;
					acc_n   = '0;
					donly_n = 1'b0;
					dseen_n = 1'b0;
					cand_n  = '1;
				end
			end else if (rx_byte == atrlp_pkg::CH_COLON && ipd_ok) begin
				pl_n    = PL_W'(acc_q);
				chunk_n = '0;
				cnt_n   = '0;
				acc_n   = '0;
				donly_n = 1'b0;
				dseen_n = 1'b0;
				cand_n  = '1;
			end else if (cnt_q >= CNT_W'(LINE_BYTES - 1)) begin
				// overflow: drop the byte and the line
				err_n   = 1'b1;
				cnt_n   = '0;
				acc_n   = '0;
				donly_n = 1'b0;
				dseen_n = 1'b0;
				cand_n  = '1;
			end else begin
				wr_en = 1'b1;
				cnt_n = cnt_q + 1'b1;
				for (int k = 0; k < atrlp_pkg::NCAND; k++) begin
					if (!(atrlp_pkg::CAND_PREFIX[k]
						&& cnt6 >= 6'(atrlp_pkg::CAND_LEN[k]))) begin
						cand_n[k] = cand_q[k] && atrlp_pkg::cand_char_eq(k, cnt6, rx_byte);
					end
				end
				if (rx_byte == atrlp_pkg::CH_COMMA) begin
					donly_n = 1'b1;
					dseen_n = 1'b0;
					acc_n   = '0;
				end else if (is_digit) begin
					if (donly_q) begin
						acc_n = (prod > PRD_W'(PAYLOAD_MAX)) ? ACC_W'(PAYLOAD_MAX + 1)
							: ACC_W'(prod);
					end
					dseen_n = 1'b1;
				end else begin
					donly_n = 1'b0;
				end
			end
		end

		res.ok     = ok_n;
		res.err    = err_n;
		res.prompt = prompt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pl_q     <= '0;
			chunk_q  <= '0;
			ok_q     <= 1'b0;
			err_q    <= 1'b0;
			prompt_q <= 1'b0;
			acc_q    <= '0;
			donly_q  <= 1'b0;
			dseen_q  <= 1'b0;
			cand_q   <= '1;
		end else if (accept) begin
			cnt_q    <= cnt_n;
			pl_q     <= pl_n;
			chunk_q  <= chunk_n;
			ok_q     <= ok_n;
			err_q    <= err_n;
			prompt_q <= prompt_n;
			acc_q    <= acc_n;
			donly_q  <= donly_n;
			dseen_q  <= dseen_n;
			cand_q   <= cand_n;
		end
	end

endmodule

>>> rtl/core/atrlp_emit.sv
module atrlp_emit #(
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  atrlp_pkg::res_t  res_in,
	input  logic [CNT_W-1:0] run_n,
	input  logic [7:0]       rd_data,
	output logic [CNT_W-1:0] rd_addr,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output atrlp_pkg::res_t  res_out
);

	atrlp_pkg::emit_state_t state_q, state_n;
	logic [CNT_W-1:0]       idx_q, run_n_q;
	atrlp_pkg::res_t        tmpl_q, out_q, run_res;
	logic                   out_valid_q;
	logic                   out_free, load_run, run_end;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		load_run = 1'b0;
		in_ready = 1'b0;
		state_n  = state_q;
		run_end  = idx_q == CNT_W'(run_n_q - 1'b1);
		unique case (state_q)
			atrlp_pkg::ST_IDLE: begin
				in_ready = out_free;
				if (accept && res_in.kind == atrlp_pkg::KIND_LINE) begin
					state_n = atrlp_pkg::ST_EMIT;
				end
			end
			atrlp_pkg::ST_EMIT: begin
				load_run = out_free;
				if (load_run && run_end) begin
					state_n = atrlp_pkg::ST_IDLE;
				end
			end
			default: state_n = atrlp_pkg::ST_IDLE;
		endcase
		// advance the read address with the load so the line store reads the next char at the same edge
		rd_addr = load_run ? CNT_W'(idx_q + 1'b1) : idx_q;

		run_res      = tmpl_q;
		run_res.data = rd_data;
		run_res.last = run_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= atrlp_pkg::ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_run) begin
				idx_q <= run_end ? '0 : CNT_W'(idx_q + 1'b1);
			end
			if ((accept && res_in.kind != atrlp_pkg::KIND_LINE) || load_run) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tmpl_q  <= res_in;
			run_n_q <= run_n;
		end
		if (accept && res_in.kind != atrlp_pkg::KIND_LINE) begin
			out_q <= res_in;
		end else if (load_run) begin
			out_q <= run_res;
		end
	end

	assign out_valid = out_valid_q;
	assign res_out   = out_q;

endmodule

>>> rtl/core/at_response_line_parser_unit.sv
// channel | signals                                    | item accepted when
// --------+--------------------------------------------+----------------------
// in      | in_valid, in_ready, cmd, rx_byte           | in_valid & in_ready
// out     | out_valid, out_ready, kind, data_byte,     | out_valid & out_ready
//         | run_last, line_class, ok/error/prompt_seen |
//
// An arm, payload or non-terminating byte gives one result, registered on
// acceptance. A line feed on a line of n characters gives n results, one a cycle
// while the output is not stalled, paced by the single read port of the line
// store; no input is taken until the last is registered. Reset clears all
// control state; the line store needs no clearing pass. A stalled output holds
// its result; input is taken only once the output frees.
module at_response_line_parser_unit #(
	parameter int              LINE_BYTES  = 64,
	parameter int              CHUNK_BYTES = 64,
	parameter longint unsigned PAYLOAD_MAX = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic       run_last,
	output logic [1:0] line_class,
	output logic       ok_seen,
	output logic       error_seen,
	output logic       prompt_seen
);

	localparam int CNT_W = $clog2(LINE_BYTES);

	logic             accept;
	atrlp_pkg::res_t  lex_res, out_res;
	logic [CNT_W-1:0] run_n, wr_addr, rd_addr;
	logic             wr_en;
	logic [7:0]       rd_data;

	assign accept = in_valid && in_ready;

	atrlp_lex #(
		.LINE_BYTES  (LINE_BYTES),
		.CHUNK_BYTES (CHUNK_BYTES),
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_lex (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.rx_byte (rx_byte),
		.res     (lex_res),
		.run_n   (run_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr)
	);

	atrlp_ram #(
		.WIDTH (8),
		.DEPTH (LINE_BYTES)
	) u_line_store (
		.clk     (clk),
		.wr_en   (wr_en && accept),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	atrlp_emit #(
		.CNT_W (CNT_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res_in    (lex_res),
		.run_n     (run_n),
		.rd_data   (rd_data),
		.rd_addr   (rd_addr),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (out_res)
	);

	assign kind        = out_res.kind;
	assign data_byte   = out_res.data;
	assign run_last    = out_res.last;
	assign line_class  = out_res.cls;
	assign ok_seen     = out_res.ok;
	assign error_seen  = out_res.err;
	assign prompt_seen = out_res.prompt;

endmodule

>>> rtl/core/atrlp_chk.sv
module atrlp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       cmd,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic       run_last,
	input logic [1:0] line_class,
	input logic       ok_seen,
	input logic       error_seen,
	input logic       prompt_seen
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(kind)
			&& $stable(run_last))
		else $error("result changed under stall");

	// no input is taken while a line run is still going out
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == atrlp_pkg::KIND_LINE && !run_last |-> !in_ready)
		else $error("input taken in the middle of a line run");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == atrlp_pkg::KIND_STATUS
			|-> data_byte == 8'd0 && !run_last && line_class == atrlp_pkg::CLS_OTHER)
		else $error("status result carries data");

	// an arm item shows cleared flags on its result in the next cycle
	a_arm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == atrlp_pkg::CMD_ARM
			|=> out_valid && kind == atrlp_pkg::KIND_STATUS && !ok_seen && !error_seen
				&& !prompt_seen)
		else $error("arm did not clear the flags");

	a_payload_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == atrlp_pkg::KIND_PAYLOAD |-> line_class == atrlp_pkg::CLS_OTHER)
		else $error("payload byte carries a line class");

endmodule

bind at_response_line_parser_unit atrlp_chk u_atrlp_chk (.*);
